// File: rtl/ipd_pkg.sv
// Package for the IR pulse-distance decoder.
// Holds the shared types, mode codes, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package ipd_pkg;

    localparam logic [1:0] MODE_RISE  = 2'd0;
    localparam logic [1:0] MODE_FALL  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] REG_HOLD_TIME = 2'd0;
    localparam logic [1:0] REG_BUTTON0   = 2'd1;
    localparam logic [1:0] REG_BUTTON1   = 2'd2;
    localparam logic [1:0] REG_BUTTON2   = 2'd3;

    localparam logic [1:0] BUTTON_0 = 2'd0;
    localparam logic [1:0] BUTTON_1 = 2'd1;
    localparam logic [1:0] BUTTON_2 = 2'd2;

    localparam logic [19:0] HOLD_TIME_RESET = 20'd110000;
    localparam logic [31:0] BUTTON0_RESET   = 32'ha25dc837;
    localparam logic [31:0] BUTTON1_RESET   = 32'ha25da857;
    localparam logic [31:0] BUTTON2_RESET   = 32'ha25d9867;

    localparam logic [5:0]  FRAME_BITS    = 6'd32;
    localparam logic [15:0] REPEAT_MAX    = 16'hffff;
    localparam logic [63:0] WINDOW_FOREVER = 64'hffff_ffff_ffff_ffff;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_LEADER = 3'b010,
        PH_DATA   = 3'b100
    } t_phase;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] time_us;
        logic [1:0]  button_index;
        logic [63:0] delta;
        logic [63:0] window_new;
    } t_cap;

    typedef struct packed {
        logic leader;
        logic gt2;
        logic eq3;
        logic eq4;
        logic eq8;
    } t_flags;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] time_us;
        logic [1:0]  button_index;
        logic [63:0] window_new;
        t_flags      flags;
    } t_cls;

endpackage

// File: rtl/ipd_capture.sv
// Input stage of the IR decoder: registers the transaction, times it against
// the previous edge and precomputes the new window end. Uses ipd_pkg.
`timescale 1ns / 1ps

module ipd_capture (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [1:0]     i_mode,
    input  logic [63:0]    i_time_us,
    input  logic [1:0]     i_button_index,
    input  logic [19:0]    i_hold_time_us,
    input  logic           i_next_ready,
    output logic           o_valid,
    output ipd_pkg::t_cap  o_cap
);

    logic          r_valid;
    logic [63:0]   r_last_edge;
    ipd_pkg::t_cap r_cap;
    logic          w_ready;
    logic          w_accept;
    logic          w_edge;

    assign w_ready    = !r_valid || i_next_ready;
    assign w_accept   = i_in_valid && w_ready;
    assign w_edge     = (i_mode == ipd_pkg::MODE_RISE) || (i_mode == ipd_pkg::MODE_FALL);
    assign o_in_stall = !w_ready;
    assign o_valid    = r_valid;
    assign o_cap      = r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_last_edge <= '0;
        end else begin
            if (w_ready) begin
                r_valid <= i_in_valid;
            end
            if (w_accept && w_edge) begin
                r_last_edge <= i_time_us;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cap.mode         <= i_mode;
            r_cap.time_us      <= i_time_us;
            r_cap.button_index <= i_button_index;
            r_cap.delta        <= i_time_us - r_last_edge;
            r_cap.window_new   <= i_time_us + {44'd0, i_hold_time_us};
        end
    end

endmodule

// File: rtl/ipd_classify.sv
// Second stage of the IR decoder: sorts the edge interval into the unit
// counts that the decoder acts on. Uses ipd_pkg.
`timescale 1ns / 1ps

module ipd_classify #(
    parameter int UNIT_US = 562
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ipd_pkg::t_cap i_cap,
    input  logic          i_next_ready,
    output logic          o_ready,
    output logic          o_valid,
    output ipd_pkg::t_cls o_cls
);

    // interval rounds to k units when k*U - U/2 <= delta < (k+1)*U - U/2
    localparam int HALF = UNIT_US / 2;
    localparam logic [63:0] THR3  = 64'(3 * UNIT_US - HALF);
    localparam logic [63:0] THR4  = 64'(4 * UNIT_US - HALF);
    localparam logic [63:0] THR5  = 64'(5 * UNIT_US - HALF);
    localparam logic [63:0] THR8  = 64'(8 * UNIT_US - HALF);
    localparam logic [63:0] THR9  = 64'(9 * UNIT_US - HALF);
    localparam logic [63:0] THR15 = 64'(15 * UNIT_US - HALF);
    localparam logic [63:0] THR18 = 64'(18 * UNIT_US - HALF);

    logic           r_valid;
    ipd_pkg::t_cls  r_cls;
    ipd_pkg::t_flags w_flags;

    assign o_ready = !r_valid || i_next_ready;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    always_comb begin
        w_flags.gt2    = i_cap.delta >= THR3;
        w_flags.eq3    = (i_cap.delta >= THR3) && (i_cap.delta < THR4);
        w_flags.eq4    = (i_cap.delta >= THR4) && (i_cap.delta < THR5);
        w_flags.eq8    = (i_cap.delta >= THR8) && (i_cap.delta < THR9);
        w_flags.leader = (i_cap.delta >= THR15) && (i_cap.delta < THR18);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cls.mode         <= i_cap.mode;
            r_cls.time_us      <= i_cap.time_us;
            r_cls.button_index <= i_cap.button_index;
            r_cls.window_new   <= i_cap.window_new;
            r_cls.flags        <= w_flags;
        end
    end

endmodule

// File: rtl/ipd_state.sv
// Decode stage of the IR decoder: frame state, repeat counter, hold window,
// button query and the result register. Uses ipd_pkg.
`timescale 1ns / 1ps

module ipd_state (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ipd_pkg::t_cls i_cls,
    output logic          o_ready,
    input  logic [31:0]   i_button0_code,
    input  logic [31:0]   i_button1_code,
    input  logic [31:0]   i_button2_code,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [31:0]   o_code,
    output logic          o_pressed,
    output logic [15:0]   o_repeat_count
);

    ipd_pkg::t_phase r_phase, n_phase;
    logic [31:0]     r_frame_bits, n_frame_bits;
    logic [15:0]     r_repeat, n_repeat;
    logic [63:0]     r_window_end, n_window_end;
    logic [5:0]      r_bit_count, n_bit_count;
    logic            r_out_valid;
    logic [31:0]     r_code;
    logic            r_pressed;
    logic [15:0]     r_repeat_count;
    logic            n_pressed;
    logic            w_step;
    logic            w_match;

    assign o_ready        = !r_out_valid || !i_out_stall;
    assign w_step         = i_valid && o_ready;
    assign o_out_valid    = r_out_valid;
    assign o_code         = r_code;
    assign o_pressed      = r_pressed;
    assign o_repeat_count = r_repeat_count;

    always_comb begin
        case (i_cls.button_index)
            ipd_pkg::BUTTON_0: w_match = r_frame_bits == i_button0_code;
            ipd_pkg::BUTTON_1: w_match = r_frame_bits == i_button1_code;
            ipd_pkg::BUTTON_2: w_match = r_frame_bits == i_button2_code;
            default:           w_match = 1'b0;
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_frame_bits = r_frame_bits;
        n_repeat     = r_repeat;
        n_window_end = r_window_end;
        n_bit_count  = r_bit_count;
        n_pressed    = 1'b0;
        case (i_cls.mode)
            ipd_pkg::MODE_RISE, ipd_pkg::MODE_FALL: begin
                // expire the hold window first
                if (r_window_end < i_cls.time_us) begin
                    n_repeat     = '0;
                    n_frame_bits = '0;
                    n_phase      = ipd_pkg::PH_IDLE;
                    n_window_end = ipd_pkg::WINDOW_FOREVER;
                end
                if (i_cls.mode == ipd_pkg::MODE_RISE) begin
                    if (i_cls.flags.leader) begin
                        n_phase = ipd_pkg::PH_LEADER;
                    end else if (i_cls.flags.gt2) begin
                        n_phase = ipd_pkg::PH_IDLE;
                    end
                end else begin
                    case (n_phase)
                        ipd_pkg::PH_LEADER: begin
                            if (i_cls.flags.eq8) begin
                                n_phase      = ipd_pkg::PH_DATA;
                                n_frame_bits = '0;
                                n_bit_count  = '0;
                            end else if (i_cls.flags.eq4) begin
                                if (n_repeat != ipd_pkg::REPEAT_MAX) begin
                                    n_repeat = n_repeat + 16'd1;
                                end
                                n_phase      = ipd_pkg::PH_IDLE;
                                n_window_end = i_cls.window_new;
                            end
                        end
                        ipd_pkg::PH_DATA: begin
                            n_frame_bits = {n_frame_bits[30:0], i_cls.flags.eq3};
                            n_bit_count  = r_bit_count + 6'd1;
                            if (n_bit_count == ipd_pkg::FRAME_BITS) begin
                                if ((n_frame_bits[31:24] == ~n_frame_bits[23:16]) &&
                                    (n_frame_bits[15:8] == ~n_frame_bits[7:0])) begin
                                    n_window_end = i_cls.window_new;
                                end
                                n_phase = ipd_pkg::PH_IDLE;
                            end
                        end
                        default: begin
                            n_phase = ipd_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            ipd_pkg::MODE_QUERY: begin
                n_pressed = w_match && (i_cls.time_us < r_window_end);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= ipd_pkg::PH_IDLE;
            r_frame_bits <= '0;
            r_repeat     <= '0;
            r_window_end <= '0;
            r_bit_count  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (w_step) begin
                r_phase      <= n_phase;
                r_frame_bits <= n_frame_bits;
                r_repeat     <= n_repeat;
                r_window_end <= n_window_end;
                r_bit_count  <= n_bit_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_code         <= n_frame_bits;
            r_pressed      <= n_pressed;
            r_repeat_count <= n_repeat;
        end
    end

    a_data_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == ipd_pkg::PH_DATA |-> r_bit_count < ipd_pkg::FRAME_BITS)
        else $error("bit count past frame length in data phase");

    a_data_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ipd_pkg::PH_DATA && r_bit_count == '0) |-> r_frame_bits == '0)
        else $error("frame not cleared at data start");

    a_hold_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> $stable(r_frame_bits) && $stable(r_repeat) && $stable(r_window_end))
        else $error("decoder state changed without a transaction");

    a_result_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_code == r_frame_bits && r_repeat_count == r_repeat)
        else $error("result does not reflect updated state");

endmodule

// File: rtl/ir_pulse_distance_decoder.sv
// Top level of the NEC-style IR pulse-distance decoder.
// Holds the configuration registers; uses ipd_pkg, ipd_capture, ipd_classify, ipd_state.
//
// Input channel (i_in_valid / o_in_stall): one transaction per edge or query.
//   i_mode 0 is a rising edge, 1 a falling edge, 2 a button query; 3 is ignored.
//   i_time_us is the free-running microsecond time of the edge or query.
// Output channel (o_out_valid / i_out_stall): exactly one result per input
//   transaction, in order: held code, pressed flag (queries only), repeat count.
// Accepted transactions pass the capture, classify and state registers; one is taken
//   per cycle while o_in_stall is low. The stages are input/interval subtract, interval
//   classification against unit thresholds, and decode with the result register.
// A stalled result holds; earlier stages keep filling until the pipeline is
//   full, then o_in_stall rises.
// Configuration (i_cfg_we, i_cfg_index, i_cfg_data) is for the user to write with the block
//   idle; the block does not enforce this. Index 0 hold time (low 20 bits), 1..3 button codes.
// Synchronous reset clears the pipeline, the decode state and restores the
//   configuration defaults.
`timescale 1ns / 1ps

module ir_pulse_distance_decoder #(
    parameter int UNIT_US = 562
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_time_us,
    input  logic [1:0]  i_button_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_code,
    output logic        o_pressed,
    output logic [15:0] o_repeat_count,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [19:0]   r_hold_time_us;
    logic [31:0]   r_button0_code;
    logic [31:0]   r_button1_code;
    logic [31:0]   r_button2_code;

    logic          w_cap_valid;
    ipd_pkg::t_cap w_cap;
    logic          w_cls_ready;
    logic          w_cls_valid;
    ipd_pkg::t_cls w_cls;
    logic          w_state_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_time_us <= ipd_pkg::HOLD_TIME_RESET;
            r_button0_code <= ipd_pkg::BUTTON0_RESET;
            r_button1_code <= ipd_pkg::BUTTON1_RESET;
            r_button2_code <= ipd_pkg::BUTTON2_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ipd_pkg::REG_HOLD_TIME: r_hold_time_us <= i_cfg_data[19:0];
                ipd_pkg::REG_BUTTON0:   r_button0_code <= i_cfg_data;
                ipd_pkg::REG_BUTTON1:   r_button1_code <= i_cfg_data;
                ipd_pkg::REG_BUTTON2:   r_button2_code <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ipd_capture u_capture (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_time_us      (i_time_us),
        .i_button_index (i_button_index),
        .i_hold_time_us (r_hold_time_us),
        .i_next_ready   (w_cls_ready),
        .o_valid        (w_cap_valid),
        .o_cap          (w_cap)
    );

    ipd_classify #(
        .UNIT_US (UNIT_US)
    ) u_classify (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_cap_valid),
        .i_cap        (w_cap),
        .i_next_ready (w_state_ready),
        .o_ready      (w_cls_ready),
        .o_valid      (w_cls_valid),
        .o_cls        (w_cls)
    );

    ipd_state u_state (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_cls_valid),
        .i_cls          (w_cls),
        .o_ready        (w_state_ready),
        .i_button0_code (r_button0_code),
        .i_button1_code (r_button1_code),
        .i_button2_code (r_button2_code),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_code         (o_code),
        .o_pressed      (o_pressed),
        .o_repeat_count (o_repeat_count)
    );

endmodule
